FILE: design/glfba_pkg.sv
// ----------------------------------------------------------------------------
// glfba_pkg
// Shared types, codes and the control store of the grouped free-block
// allocator: payload structs, status codes, microcode word layout and the
// read-only microprogram with its dispatch map.
// ----------------------------------------------------------------------------
package glfba_pkg;

	// Fixed field widths of the request and response payloads.
	localparam int ID_W     = 10;
	localparam int FREE_W   = 11;
	localparam int STATUS_W = 2;

	localparam logic [FREE_W-1:0] FREE_MAX = '1;

	// Command codes.
	localparam logic CMD_FREE  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;

	typedef struct packed {
		logic            command;
		logic [ID_W-1:0] block_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]     granted_id;
		logic [STATUS_W-1:0] status;
		logic [FREE_W-1:0]   free_total;
	} rsp_t;

	// Datapath actions selected by one microcode word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_SETUP,
		OP_PUSH,
		OP_POP,
		OP_BAD,
		OP_EMPTY,
		OP_SPILL,
		OP_SPILL_END,
		OP_RLD_FIRST,
		OP_RLD,
		OP_RLD_END,
		OP_EMIT
	} op_t;

	// Sequencing kinds.
	typedef enum logic [2:0] {
		J_NEXT,      // fall through
		J_GOTO,      // unconditional jump
		J_WAIT_IN,   // hold until a request transfer, then fall through
		J_DISPATCH,  // multiway jump on the decoded item class
		J_LOOP,      // jump to target while words remain, else fall through
		J_WAIT_OUT   // hold while the response register is full and not taken, then jump
	} jmp_t;

	// Item classes found in the decode step.
	typedef enum logic [2:0] {
		CLS_BAD_ID,
		CLS_EMPTY,
		CLS_PUSH,
		CLS_SPILL,
		CLS_POP,
		CLS_RELOAD
	} cls_t;

	localparam int UPC_W = 4;

	// Microprogram addresses.
	localparam logic [UPC_W-1:0] U_FETCH     = 4'd0;
	localparam logic [UPC_W-1:0] U_DECODE    = 4'd1;
	localparam logic [UPC_W-1:0] U_PUSH      = 4'd2;
	localparam logic [UPC_W-1:0] U_POP       = 4'd3;
	localparam logic [UPC_W-1:0] U_BAD       = 4'd4;
	localparam logic [UPC_W-1:0] U_EMPTY     = 4'd5;
	localparam logic [UPC_W-1:0] U_SPILL     = 4'd6;
	localparam logic [UPC_W-1:0] U_SPILL_END = 4'd7;
	localparam logic [UPC_W-1:0] U_RLD_FIRST = 4'd8;
	localparam logic [UPC_W-1:0] U_RLD       = 4'd9;
	localparam logic [UPC_W-1:0] U_RLD_END   = 4'd10;
	localparam logic [UPC_W-1:0] U_EMIT      = 4'd11;

	typedef struct packed {
		op_t              op;
		jmp_t             jmp;
		logic [UPC_W-1:0] target;
	} ucw_t;

	// Status returned by the datapath to the sequencer.
	typedef struct packed {
		logic accept;
		cls_t cls;
		logic more;
		logic out_busy;
	} dp_stat_t;

	// Control store.
	function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucw_t w;
		unique case (upc)
			U_FETCH:     w = '{op: OP_FETCH,     jmp: J_WAIT_IN,  target: U_FETCH};
			U_DECODE:    w = '{op: OP_SETUP,     jmp: J_DISPATCH, target: U_FETCH};
			U_PUSH:      w = '{op: OP_PUSH,      jmp: J_GOTO,     target: U_EMIT};
			U_POP:       w = '{op: OP_POP,       jmp: J_GOTO,     target: U_EMIT};
			U_BAD:       w = '{op: OP_BAD,       jmp: J_GOTO,     target: U_EMIT};
			U_EMPTY:     w = '{op: OP_EMPTY,     jmp: J_GOTO,     target: U_EMIT};
			U_SPILL:     w = '{op: OP_SPILL,     jmp: J_LOOP,     target: U_SPILL};
			U_SPILL_END: w = '{op: OP_SPILL_END, jmp: J_GOTO,     target: U_EMIT};
			U_RLD_FIRST: w = '{op: OP_RLD_FIRST, jmp: J_NEXT,     target: U_FETCH};
			U_RLD:       w = '{op: OP_RLD,       jmp: J_LOOP,     target: U_RLD};
			U_RLD_END:   w = '{op: OP_RLD_END,   jmp: J_GOTO,     target: U_EMIT};
			U_EMIT:      w = '{op: OP_EMIT,      jmp: J_WAIT_OUT, target: U_FETCH};
			default:     w = '{op: OP_NOP,       jmp: J_GOTO,     target: U_FETCH};
		endcase
		return w;
	endfunction

	// Dispatch map from item class to the first step of its routine.
	function automatic logic [UPC_W-1:0] dispatch(input cls_t cls);
		logic [UPC_W-1:0] a;
		unique case (cls)
			CLS_BAD_ID: a = U_BAD;
			CLS_EMPTY:  a = U_EMPTY;
			CLS_PUSH:   a = U_PUSH;
			CLS_SPILL:  a = U_SPILL;
			CLS_POP:    a = U_POP;
			CLS_RELOAD: a = U_RLD_FIRST;
			default:    a = U_FETCH;
		endcase
		return a;
	endfunction

endpackage

FILE: design/glfba_ram.sv
// ----------------------------------------------------------------------------
// glfba_ram
// Generic single-port RAM with one write or read address per cycle and a
// registered read.
// ----------------------------------------------------------------------------
module glfba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 11264
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/glfba_useq.sv
// ----------------------------------------------------------------------------
// glfba_useq
// Microcode sequencer: holds the step counter, reads the control word from
// the control store and picks the next step from the datapath status.
// ----------------------------------------------------------------------------
module glfba_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  glfba_pkg::dp_stat_t stat,
	output glfba_pkg::ucw_t     ctl
);

	logic [glfba_pkg::UPC_W-1:0] upc_q;
	logic [glfba_pkg::UPC_W-1:0] upc_next;
	logic [glfba_pkg::UPC_W-1:0] upc_inc;

	assign ctl     = glfba_pkg::ucode_rom(upc_q);
	assign upc_inc = upc_q + glfba_pkg::UPC_W'(1);

	// Next-step selection.
	always_comb begin
		unique case (ctl.jmp)
			glfba_pkg::J_NEXT:     upc_next = upc_inc;
			glfba_pkg::J_GOTO:     upc_next = ctl.target;
			glfba_pkg::J_WAIT_IN:  upc_next = stat.accept ? upc_inc : upc_q;
			glfba_pkg::J_DISPATCH: upc_next = glfba_pkg::dispatch(stat.cls);
			glfba_pkg::J_LOOP:     upc_next = stat.more ? ctl.target : upc_inc;
			glfba_pkg::J_WAIT_OUT: upc_next = stat.out_busy ? upc_q : ctl.target;
			default:               upc_next = glfba_pkg::U_FETCH;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= glfba_pkg::U_FETCH;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

FILE: design/glfba_dp.sv
// ----------------------------------------------------------------------------
// glfba_dp
// Allocator datapath: the resident group frame, the free counter, the store
// address and word counters, the result holding registers and the request
// and response handshakes. Every action is selected by the control word.
// ----------------------------------------------------------------------------
module glfba_dp #(
	parameter int GROUP_SIZE = 10,
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  glfba_pkg::ucw_t                               ctl,
	output glfba_pkg::dp_stat_t                           stat,
	input  logic                                          req_valid,
	output logic                                          req_ready,
	input  glfba_pkg::req_t                               req,
	output logic                                          rsp_valid,
	input  logic                                          rsp_ready,
	output glfba_pkg::rsp_t                               rsp,
	output logic                                          mem_we,
	output logic [$clog2(NUM_BLOCKS*(GROUP_SIZE+1))-1:0]  mem_addr,
	output logic [glfba_pkg::ID_W-1:0]                    mem_wdata,
	input  logic [glfba_pkg::ID_W-1:0]                    mem_rdata
);

	localparam int WORDS  = GROUP_SIZE + 1;
	localparam int WIDX_W = $clog2(WORDS);
	localparam int ADDR_W = $clog2(NUM_BLOCKS * WORDS);
	localparam int PROD_W = glfba_pkg::ID_W + $clog2(WORDS + 1);
	localparam int IDX_W  = glfba_pkg::ID_W + 1;

	localparam logic [WIDX_W-1:0]           LAST_WORD = WIDX_W'(WORDS - 1);
	localparam logic [IDX_W-1:0]            WORDS_I   = IDX_W'(WORDS);
	localparam logic [PROD_W-1:0]           WORDS_P   = PROD_W'(WORDS);
	localparam logic [glfba_pkg::ID_W-1:0]  CAP_LINK  = glfba_pkg::ID_W'(GROUP_SIZE);
	localparam logic [glfba_pkg::ID_W-1:0]  CAP_LAST  = glfba_pkg::ID_W'(GROUP_SIZE - 1);

	// Frame word 0 is the count, word 1 the link, the rest hold free ids.
	logic [glfba_pkg::ID_W-1:0]     frame_q [WORDS];
	logic                           cmd_q;
	logic [glfba_pkg::ID_W-1:0]     id_q;
	logic [glfba_pkg::FREE_W-1:0]   free_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [WIDX_W-1:0]              wc_q;
	logic [glfba_pkg::ID_W-1:0]     res_granted_q;
	logic [glfba_pkg::STATUS_W-1:0] res_status_q;
	logic                           rsp_valid_q;
	glfba_pkg::rsp_t                rsp_q;

	logic [glfba_pkg::ID_W-1:0] count;
	logic [glfba_pkg::ID_W-1:0] link;
	logic                       linked;
	logic                       full;
	logic                       id_bad;
	logic [IDX_W-1:0]           push_idx;
	logic [IDX_W-1:0]           pop_idx;
	logic                       push_ok;
	logic                       pop_ok;
	logic [glfba_pkg::ID_W-1:0] pop_word;
	logic [glfba_pkg::ID_W-1:0] base;
	logic [PROD_W-1:0]          base_prod;
	logic                       accept;
	logic                       out_busy;
	logic                       free_inc;
	logic                       free_dec;

	assign count  = frame_q[0];
	assign link   = frame_q[1];
	assign linked = (link != '0);
	assign full   = count >= (linked ? CAP_LINK : CAP_LAST);
	assign id_bad = (id_q == '0) || (32'(id_q) >= NUM_BLOCKS);

	// The last group keeps its ids one word further up, after the zero link.
	assign push_idx = {1'b0, count} + (linked ? IDX_W'(1) : IDX_W'(2));
	assign pop_idx  = {1'b0, count} + (linked ? IDX_W'(0) : IDX_W'(1));
	assign push_ok  = push_idx < WORDS_I;
	assign pop_ok   = pop_idx < WORDS_I;
	assign pop_word = pop_ok ? frame_q[pop_idx[WIDX_W-1:0]] : '0;

	// Group image address: an allocate reloads from the link, a free spills
	// to the freed id.
	assign base      = (cmd_q == glfba_pkg::CMD_ALLOC) ? link : id_q;
	assign base_prod = PROD_W'(base) * WORDS_P;

	assign req_ready = (ctl.op == glfba_pkg::OP_FETCH);
	assign accept    = req_valid && req_ready;
	assign out_busy  = rsp_valid_q && !rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign mem_we    = (ctl.op == glfba_pkg::OP_SPILL);
	assign mem_addr  = addr_q;
	assign mem_wdata = frame_q[0];

	assign free_inc = (ctl.op == glfba_pkg::OP_PUSH) || (ctl.op == glfba_pkg::OP_SPILL_END);
	assign free_dec = (ctl.op == glfba_pkg::OP_POP) || (ctl.op == glfba_pkg::OP_RLD_END);

	// Item classification for the dispatch step.
	always_comb begin
		stat.accept   = accept;
		stat.more     = (wc_q != LAST_WORD);
		stat.out_busy = out_busy;
		if (cmd_q == glfba_pkg::CMD_FREE) begin
			if (id_bad) begin
				stat.cls = glfba_pkg::CLS_BAD_ID;
			end else if (full) begin
				stat.cls = glfba_pkg::CLS_SPILL;
			end else begin
				stat.cls = glfba_pkg::CLS_PUSH;
			end
		end else begin
			if (count == '0) begin
				stat.cls = glfba_pkg::CLS_EMPTY;
			end else if ((count == glfba_pkg::ID_W'(1)) && linked) begin
				stat.cls = glfba_pkg::CLS_RELOAD;
			end else begin
				stat.cls = glfba_pkg::CLS_POP;
			end
		end
	end

	// Resident group frame. A spill rotates it once around through word 0;
	// a reload shifts store words in at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				frame_q[i] <= '0;
			end
		end else begin
			unique case (ctl.op)
				glfba_pkg::OP_PUSH: begin
					frame_q[0] <= count + glfba_pkg::ID_W'(1);
					for (int i = 1; i < WORDS; i++) begin
						if (push_ok && (WIDX_W'(i) == push_idx[WIDX_W-1:0])) begin
							frame_q[i] <= id_q;
						end
					end
				end
				glfba_pkg::OP_POP: begin
					frame_q[0] <= count - glfba_pkg::ID_W'(1);
				end
				glfba_pkg::OP_SPILL: begin
					for (int i = 0; i < WORDS - 1; i++) begin
						frame_q[i] <= frame_q[i+1];
					end
					frame_q[WORDS-1] <= frame_q[0];
				end
				glfba_pkg::OP_SPILL_END: begin
					frame_q[0] <= glfba_pkg::ID_W'(1);
					frame_q[1] <= id_q;
				end
				glfba_pkg::OP_RLD: begin
					for (int i = 0; i < WORDS - 1; i++) begin
						frame_q[i] <= frame_q[i+1];
					end
					frame_q[WORDS-1] <= mem_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Free counter, saturating at both ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (free_inc && (free_q != glfba_pkg::FREE_MAX)) begin
			free_q <= free_q + glfba_pkg::FREE_W'(1);
		end else if (free_dec && (free_q != '0)) begin
			free_q <= free_q - glfba_pkg::FREE_W'(1);
		end
	end

	// Request capture, store address and word counters, result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			id_q  <= req.block_id;
		end
		unique case (ctl.op)
			glfba_pkg::OP_SETUP: begin
				addr_q <= ADDR_W'(base_prod);
				wc_q   <= '0;
			end
			glfba_pkg::OP_PUSH, glfba_pkg::OP_SPILL_END: begin
				res_granted_q <= '0;
				res_status_q  <= glfba_pkg::ST_OK;
			end
			glfba_pkg::OP_POP: begin
				res_granted_q <= pop_word;
				res_status_q  <= glfba_pkg::ST_OK;
			end
			glfba_pkg::OP_BAD: begin
				res_granted_q <= '0;
				res_status_q  <= glfba_pkg::ST_BAD_ID;
			end
			glfba_pkg::OP_EMPTY: begin
				res_granted_q <= '0;
				res_status_q  <= glfba_pkg::ST_EMPTY;
			end
			glfba_pkg::OP_RLD_FIRST: begin
				// The link block itself is handed out before the frame is replaced.
				res_granted_q <= link;
				res_status_q  <= glfba_pkg::ST_OK;
				addr_q        <= addr_q + ADDR_W'(1);
			end
			glfba_pkg::OP_SPILL, glfba_pkg::OP_RLD: begin
				addr_q <= addr_q + ADDR_W'(1);
				wc_q   <= wc_q + WIDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Response register: loaded in the emit step once the previous response
	// has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((ctl.op == glfba_pkg::OP_EMIT) && !out_busy) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == glfba_pkg::OP_EMIT) && !out_busy) begin
			rsp_q.granted_id <= res_granted_q;
			rsp_q.status     <= res_status_q;
			rsp_q.free_total <= free_q;
		end
	end

endmodule

FILE: design/grouped_link_free_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_link_free_block_allocator
// Grouped free-block list manager driven by a microcoded sequencer; group
// images live in a single-port RAM indexed by block id.
// ----------------------------------------------------------------------------
// A plain push, pop or error runs the fetch, decode, item and emit steps;
// a spill adds a copy loop from the frame into the RAM and a reload one
// from the RAM into the frame, one word per cycle. A new request is taken
// only after the last response has been loaded into the response register.
// Reset clears the sequencer, group frame, free counter and response valid;
// the group store is left uninitialized and needs no clearing pass.
module grouped_link_free_block_allocator #(
	parameter int GROUP_SIZE = 10,
	parameter int NUM_BLOCKS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  glfba_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output glfba_pkg::rsp_t rsp
);

	localparam int DEPTH  = NUM_BLOCKS * (GROUP_SIZE + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	glfba_pkg::ucw_t            ctl;
	glfba_pkg::dp_stat_t        stat;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_addr;
	logic [glfba_pkg::ID_W-1:0] mem_wdata;
	logic [glfba_pkg::ID_W-1:0] mem_rdata;

	// Microprogram sequencer.
	glfba_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// Datapath and handshakes.
	glfba_dp #(
		.GROUP_SIZE (GROUP_SIZE),
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// Group store.
	glfba_ram #(
		.WIDTH (glfba_pkg::ID_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// One item at a time: a request transfer is followed by a busy cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while an item is in progress");

	// The decode step always dispatches into an item routine.
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == glfba_pkg::OP_SETUP) |=>
		(ctl.op == glfba_pkg::OP_PUSH || ctl.op == glfba_pkg::OP_POP ||
		 ctl.op == glfba_pkg::OP_BAD || ctl.op == glfba_pkg::OP_EMPTY ||
		 ctl.op == glfba_pkg::OP_SPILL || ctl.op == glfba_pkg::OP_RLD_FIRST))
		else $error("decode step did not dispatch to an item routine");

	// A new response appears only out of the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(ctl.op == glfba_pkg::OP_EMIT))
		else $error("response raised outside the emit step");

	// Errors never hand out a block.
	a_err_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != glfba_pkg::ST_OK) |-> (rsp.granted_id == '0))
		else $error("error response carries a granted block");
`endif

endmodule

FILE: tb/glfba_checker.sv
// ----------------------------------------------------------------------------
// glfba_checker
// Watches the request and response channels of the grouped free-block
// allocator, keeps its own copy of the resident group, the group images and
// the free counter, predicts one response per request transfer and compares
// every response transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module glfba_checker #(
	parameter int GROUP_SIZE = 10,
	parameter int NUM_BLOCKS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  glfba_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  glfba_pkg::rsp_t rsp,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS = GROUP_SIZE + 1;

	// Word 0 is the count, word 1 the link, the rest hold free ids.
	logic [glfba_pkg::ID_W-1:0]   frame [WORDS];
	logic [glfba_pkg::ID_W-1:0]   group_image [NUM_BLOCKS][WORDS];
	logic [glfba_pkg::FREE_W-1:0] free_count;
	glfba_pkg::rsp_t              expected_grants [$];
	glfba_pkg::rsp_t              want;

	// Applies one request to the mirrored state and returns its response.
	function automatic glfba_pkg::rsp_t predict_allocation(input glfba_pkg::req_t r);
		glfba_pkg::rsp_t res;
		int              count;
		int              link;
		int              cap;
		int              slot;
		res = '{granted_id: '0, status: glfba_pkg::ST_OK, free_total: '0};
		count = int'(frame[0]);
		link = int'(frame[1]);
		// The last group keeps its ids after the zero link word.
		cap = (link != 0) ? GROUP_SIZE : GROUP_SIZE - 1;
		if (r.command == glfba_pkg::CMD_FREE) begin
			if (r.block_id == 0 || r.block_id >= NUM_BLOCKS) begin
				res.status = glfba_pkg::ST_BAD_ID;
			end else begin
				if (count < cap) begin
					slot = (link != 0) ? count + 1 : count + 2;
					if (slot < WORDS)
						frame[slot] = r.block_id;
					frame[0] = glfba_pkg::ID_W'(count + 1);
				end else begin
					// A full group is parked under the freed id, which becomes the link.
					for (int w = 0; w < WORDS; w++)
						group_image[r.block_id][w] = frame[w];
					frame[0] = glfba_pkg::ID_W'(1);
					frame[1] = r.block_id;
				end
				if (free_count != glfba_pkg::FREE_MAX)
					free_count++;
			end
		end else begin
			if (count == 0) begin
				res.status = glfba_pkg::ST_EMPTY;
			end else begin
				if (count == 1 && link != 0) begin
					// Hand out the link block and bring its group back.
					res.granted_id = glfba_pkg::ID_W'(link);
					for (int w = 0; w < WORDS; w++)
						frame[w] = (link < NUM_BLOCKS) ? group_image[link][w] : '0;
				end else begin
					slot = (link != 0) ? count : count + 1;
					res.granted_id = (slot < WORDS) ? frame[slot] : '0;
					frame[0] = glfba_pkg::ID_W'(count - 1);
				end
				if (free_count != 0)
					free_count--;
			end
		end
		res.free_total = free_count;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// Predict on each request transfer, compare on each response transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++)
				frame[w] = '0;
			free_count = '0;
			expected_grants.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (req_valid && req_ready)
				expected_grants.push_back(predict_allocation(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_grants.size() == 0) begin
					report_mismatch($sformatf(
						"response with none expected: granted_id %0d status %0d free_total %0d",
						rsp.granted_id, rsp.status, rsp.free_total));
				end else begin
					want = expected_grants.pop_front();
					if (rsp.granted_id !== want.granted_id)
						report_mismatch($sformatf("granted_id: expected %0d, got %0d",
							want.granted_id, rsp.granted_id));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status: expected %0d, got %0d",
							want.status, rsp.status));
					if (rsp.free_total !== want.free_total)
						report_mismatch($sformatf("free_total: expected %0d, got %0d",
							want.free_total, rsp.free_total));
				end
			end
			pending = expected_grants.size();
		end
	end

endmodule

FILE: tb/tb_grouped_link_free_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_grouped_link_free_block_allocator
// Drives free and allocate requests into the grouped free-block allocator:
// a directed run through empty, invalid id, group fill, spill and reload,
// then random phases that grow, drain and churn the pool. Both channels idle
// at random, and the response side once holds off long enough to back the
// block up. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_grouped_link_free_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GROUP_SIZE     = 10;
	localparam int NUM_BLOCKS     = 1024;
	localparam int RANDOM_ITEMS   = 1425;
	localparam int SQUEEZE_AT     = 700;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int IDLE_LIMIT     = 4000;
	localparam int DRAIN_CYCLES   = 40;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_ready;
	glfba_pkg::req_t req;
	logic            rsp_valid;
	logic            rsp_ready;
	glfba_pkg::rsp_t rsp;
	int              chk_fails;
	int              chk_pending;
	int              idle_cycles;
	bit              tx_quiet;
	bit              rx_quiet;
	bit              squeeze_pending;

	grouped_link_free_block_allocator #(
		.GROUP_SIZE(GROUP_SIZE),
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	glfba_checker #(
		.GROUP_SIZE(GROUP_SIZE),
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.fail_count(chk_fails),
		.pending   (chk_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Idle lengths: mostly none or short, now and then long.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one request and returns once its transfer has happened.
	task automatic offer(input logic cmd, input logic [glfba_pkg::ID_W-1:0] id);
		int gap;
		gap = tx_quiet ? 0 : idle_span();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= '{command: cmd, block_id: id};
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("grouped_link_free_block_allocator regression: fail");
			$finish;
		end
	end

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		bit squeeze_done;
		stall_left = 0;
		squeeze_done = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_pending && !squeeze_done) begin
				squeeze_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				stall_left = rx_quiet ? 0 : idle_span();
			end
		end
	end

	// Request side and verdict.
	initial begin
		phase_t                     phase;
		int                         sent;
		int                         span;
		int                         free_pct;
		logic                       cmd;
		logic [glfba_pkg::ID_W-1:0] id;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		squeeze_pending = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pool, invalid id, fill the last group, spill, pop,
		// reload through the link, drain to empty again.
		offer(glfba_pkg::CMD_ALLOC, '1);
		offer(glfba_pkg::CMD_FREE, '0);
		offer(glfba_pkg::CMD_FREE, 10'd1023);
		for (int i = 1; i <= GROUP_SIZE - 2; i++)
			offer(glfba_pkg::CMD_FREE, i[glfba_pkg::ID_W-1:0]);
		offer(glfba_pkg::CMD_FREE, 10'd512);
		offer(glfba_pkg::CMD_FREE, 10'h155);
		offer(glfba_pkg::CMD_ALLOC, '0);
		offer(glfba_pkg::CMD_ALLOC, 10'h2aa);
		for (int i = 0; i < GROUP_SIZE - 1; i++)
			offer(glfba_pkg::CMD_ALLOC, '0);
		offer(glfba_pkg::CMD_ALLOC, '1);

		// Random phases that grow, drain or churn the pool.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase = phase_t'($urandom_range(0, 2));
			span = $urandom_range(10, 60);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			case (phase)
				PH_FILL:  free_pct = 85;
				PH_DRAIN: free_pct = 15;
				default:  free_pct = 50;
			endcase
			for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
				cmd = ($urandom_range(0, 99) < free_pct) ?
					glfba_pkg::CMD_FREE : glfba_pkg::CMD_ALLOC;
				if (cmd == glfba_pkg::CMD_FREE && $urandom_range(0, 39) == 0)
					id = '0;
				else if (cmd == glfba_pkg::CMD_FREE)
					id = glfba_pkg::ID_W'($urandom_range(1, NUM_BLOCKS - 1));
				else
					id = glfba_pkg::ID_W'($urandom_range(0, (1 << glfba_pkg::ID_W) - 1));
				sent++;
				if (sent == SQUEEZE_AT)
					squeeze_pending = 1'b1;
				offer(cmd, id);
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Let the last responses come out, then watch for strays.
		while (chk_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (chk_fails == 0 && chk_pending == 0)
			$display("grouped_link_free_block_allocator regression: pass");
		else
			$display("grouped_link_free_block_allocator regression: fail");
		$finish;
	end

endmodule
